### rtl/core/fixed_block_pool_allocator_defines.svh
// Assertion macros shared by the pool allocator RTL.
// The asserting module provides i_clk and i_rst_n.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FBPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fbpa_pkg.sv
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int HEADER_BYTES_DEF = 8;

    localparam int CNT_W  = 9;
    localparam int SIZE_W = 16;
    localparam int IDX_W  = 8;
    localparam int OFS_W  = 24;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 9'd256;
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd16;

    // register index = paddr[2]
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_SIZE  = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_EMPTY  = 2'd1,
        STS_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] block_index;
        logic             no_block;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted_index;
        logic [OFS_W-1:0] payload_offset;
        logic [CNT_W-1:0] free_blocks;
    } t_out_item;

    typedef struct packed {
        logic restart;   // restart the link table rebuild
        logic sweep;     // write one link entry of the rebuild
        logic accept;    // an item is taken this cycle
        logic pop_load;  // head takes the link read for the last pop
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic pop_go;    // presented item is an allocate that will pop
    } t_sts;

endpackage

### rtl/core/fixed_block_pool_allocator.sv
// Fixed-size block pool: a LIFO free list of block indices.
// Input channel i_valid/o_ready carries one request item: allocate (pop the
// list head) or free (push block_index). Output channel o_valid/i_ready
// returns one result item per request: status, granted index, payload byte
// offset index*(block_size+HEADER_BYTES)+HEADER_BYTES, and free count.
// The result is registered and shows in the cycle after the accept.
// A free or a failed allocate leaves the input ready for the next item; a
// successful allocate first passes through ST_POP, where the new head comes
// from the link RAM, which has a registered read port.
// A result waiting on i_ready occupies the output register; a new item is
// taken in the same cycle the waiting result leaves. While the receiver
// stalls, o_ready stays low.
// Reset and every write of block_count rebuild the link RAM as the chain
// 0,1,...,N-1: a sweep of all MAX_BLOCKS entries, one entry per cycle, during
// which no item is taken. Writing block_size only affects later offsets.
// APB: block_count at 0x0, block_size at 0x4; pready is always high.
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS   = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  fbpa_pkg::t_in_item               i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output fbpa_pkg::t_out_item              o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fbpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fbpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import fbpa_pkg::*;

    logic [CNT_W-1:0]  r_block_count;
    logic [SIZE_W-1:0] r_block_size;
    logic [CNT_W-1:0]  w_eff_count;
    logic              w_wr;
    logic              w_rebuild;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready    = 1'b1;
    assign w_wr      = psel & penable & pwrite;
    assign w_rebuild = w_wr && (paddr[2] == REG_BLOCK_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RST;
            r_block_size  <= BLOCK_SIZE_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_BLOCK_COUNT: r_block_count <= pwdata[CNT_W-1:0];
                REG_BLOCK_SIZE:  r_block_size  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BLOCK_COUNT: prdata = APB_DATA_W'(r_block_count);
            REG_BLOCK_SIZE:  prdata = APB_DATA_W'(r_block_size);
            default:         prdata = '0;
        endcase
    end

    // counts above the table depth saturate
    assign w_eff_count = (32'(r_block_count) > 32'(MAX_BLOCKS)) ?
                         CNT_W'(MAX_BLOCKS) : r_block_count;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rebuild   (w_rebuild),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    fbpa_dpath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item       (i_item),
        .i_block_size (r_block_size),
        .i_eff_count  (w_eff_count),
        .o_sts        (w_sts),
        .o_result     (o_result)
    );

    `FBPA_ASSERT_NOW(a_no_accept_in_sweep, w_cmd.sweep, !o_ready, "item taken during rebuild")
    `FBPA_ASSERT_NXT(a_pop_blocks_next, w_cmd.accept && w_sts.pop_go, !o_ready, "item taken while pop pending")
    `FBPA_ASSERT_NOW(a_count_bound, o_valid, o_result.free_blocks <= w_eff_count, "free count above pool size")
    `FBPA_ASSERT_NOW(a_fail_zero, o_valid && (o_result.status != STS_OK), (o_result.granted_index == '0) && (o_result.payload_offset == '0), "failed request reports a block")

endmodule

### rtl/core/fbpa_ctrl.sv
module fbpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rebuild,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  fbpa_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output fbpa_pkg::t_cmd o_cmd
);
    import fbpa_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_IDLE = 3'b010,
        ST_POP  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        w_in_ready  = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_in_ready = (~r_out_valid | i_out_ready) & ~i_rebuild;
                if (i_in_valid && w_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_out_valid  = 1'b1;
                    if (i_sts.pop_go) begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
        if (i_rebuild) begin
            o_cmd.restart = 1'b1;
            o_cmd.sweep   = 1'b0;
            n_state       = ST_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/fbpa_dpath.sv
module fbpa_dpath #(
    parameter int MAX_BLOCKS   = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fbpa_pkg::t_cmd               i_cmd,
    input  fbpa_pkg::t_in_item           i_item,
    input  logic [fbpa_pkg::SIZE_W-1:0]  i_block_size,
    input  logic [fbpa_pkg::CNT_W-1:0]   i_eff_count,
    output fbpa_pkg::t_sts               o_sts,
    output fbpa_pkg::t_out_item          o_result
);
    import fbpa_pkg::*;

    // Link values never exceed the 9-bit count range or an 8-bit pushed index.
    localparam int CAP   = (MAX_BLOCKS < 2**CNT_W) ? MAX_BLOCKS : 2**CNT_W;
    localparam int VW    = ($clog2(CAP) > IDX_W) ? $clog2(CAP) : IDX_W;
    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int SW    = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int RS    = VW + AW;
    localparam int PW    = VW + RS;
    localparam int RECIP = (2**RS) / MAX_BLOCKS;
    localparam int MW    = VW + SIZE_W + 1;

    logic [VW-1:0]    r_link [MAX_BLOCKS];
    logic [VW-1:0]    r_rdata;
    logic [VW-1:0]    r_head;
    logic [AW-1:0]    r_slot;
    logic [CNT_W-1:0] r_count;
    logic [AW-1:0]    r_sweep;
    t_out_item        r_result;

    logic [AW:0]      w_sweep_next;
    logic [VW-1:0]    w_sweep_val;
    logic             w_sweep_last;
    logic             w_push_ok;
    logic             w_do_pop;
    logic             w_do_push;
    logic [AW-1:0]    w_free_slot;
    logic [SIZE_W:0]  w_stride;
    logic [MW-1:0]    w_offset_full;
    t_out_item        w_result;

    // value mod MAX_BLOCKS: reciprocal estimate, then one correction
    function automatic logic [AW-1:0] slot_of(input logic [VW-1:0] v);
        logic [PW-1:0] prod;
        logic [PW-1:0] qm;
        logic [VW-1:0] r;
        prod = PW'(v) * PW'(RECIP);
        qm   = (prod >> RS) * PW'(MAX_BLOCKS);
        r    = v - qm[VW-1:0];
        if (PW'(r) >= PW'(MAX_BLOCKS)) begin
            r = r - VW'(MAX_BLOCKS);
        end
        return AW'(r);
    endfunction

    assign w_sweep_next = {1'b0, r_sweep} + 1'b1;
    assign w_sweep_val  = (SW'(w_sweep_next) < SW'(i_eff_count)) ? VW'(w_sweep_next) : '0;
    assign w_sweep_last = (r_sweep == AW'(MAX_BLOCKS - 1));

    assign w_push_ok   = (r_count < i_eff_count) && !i_item.no_block;
    assign w_do_pop    = i_cmd.accept && (i_item.mode == MODE_ALLOC) && (r_count != '0);
    assign w_do_push   = i_cmd.accept && (i_item.mode == MODE_FREE) && w_push_ok;
    assign w_free_slot = slot_of(VW'(i_item.block_index));

    assign w_stride      = {1'b0, i_block_size} + (SIZE_W + 1)'(HEADER_BYTES);
    assign w_offset_full = MW'(r_head) * MW'(w_stride) + MW'(HEADER_BYTES);

    always_comb begin
        w_result.status         = STS_OK;
        w_result.granted_index  = '0;
        w_result.payload_offset = '0;
        w_result.free_blocks    = r_count;
        if (i_item.mode == MODE_ALLOC) begin
            if (r_count != '0) begin
                w_result.granted_index  = r_head[IDX_W-1:0];
                w_result.payload_offset = w_offset_full[OFS_W-1:0];
                w_result.free_blocks    = r_count - 1'b1;
            end else begin
                w_result.status = STS_EMPTY;
            end
        end else if (w_push_ok) begin
            w_result.free_blocks = r_count + 1'b1;
        end else begin
            w_result.status = STS_REJECT;
        end
    end

    // link table: one write port, registered read at the head slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_link[r_sweep] <= w_sweep_val;
        end else if (w_do_push) begin
            r_link[w_free_slot] <= r_head;
        end
        r_rdata <= r_link[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_head  <= '0;
            r_slot  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.sweep && w_sweep_last) begin
                r_head  <= '0;
                r_slot  <= '0;
                r_count <= i_eff_count;
            end else if (w_do_pop) begin
                r_count <= r_count - 1'b1;
            end else if (w_do_push) begin
                r_head  <= VW'(i_item.block_index);
                r_slot  <= w_free_slot;
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop_load) begin
                r_head <= r_rdata;
                r_slot <= slot_of(r_rdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_result <= w_result;
        end
    end

    assign o_sts.sweep_last = w_sweep_last;
    assign o_sts.pop_go     = (i_item.mode == MODE_ALLOC) && (r_count != '0);
    assign o_result         = r_result;

endmodule
